// ----- rtl/fnvbi_pkg.sv -----
package fnvbi_pkg;

    localparam logic [31:0] FNV_OFFSET_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME        = 32'd16777619;
    localparam logic [31:0] BUCKET_RESET     = 32'd256;
    localparam int unsigned DIV_STEPS        = 32;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       end_of_key;
    } t_fnvbi_req;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [31:0] bucket_index;
    } t_fnvbi_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } t_fnvbi_state;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// ----- rtl/fnv1a_bucket_index.sv -----
// Channel   Direction  Handshake              Payload
// request   in         i_valid / o_stall      i_req (key_byte, end_of_key)
// result    out        o_valid / i_stall      o_rsp (hash_value, bucket_index)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (bucket_count)
//
// A key byte request is hashed in the cycle it is accepted; bytes stream at one per cycle when idle.
// A terminator starts the restoring divider (one dividend bit per cycle) for the bucket index,
// then ST_WAIT loads the output register once it is free; requests stall until then.
// Reset is synchronous and active low; it restores the offset basis and a bucket count of 256.
// A stalled result holds in the output register while further key bytes are accepted.
module fnv1a_bucket_index (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fnvbi_pkg::t_fnvbi_req i_req,
    output logic                  o_stall,
    output logic                  o_valid,
    output fnvbi_pkg::t_fnvbi_rsp o_rsp,
    input  logic                  i_stall,
    input  logic                  i_cfg_valid,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_cfg_ready
);
    import fnvbi_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_fnvbi_state     r_state;
    t_fnvbi_state     n_state;
    logic [31:0]      r_hash;
    logic [31:0]      r_bucket;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic [31:0]      r_res_hash;
    logic [31:0]      r_dividend;
    logic [31:0]      r_rem;
    t_fnvbi_rsp       r_rsp;

    logic             req_acc;
    logic             out_acc;
    logic             out_load;
    logic [32:0]      shifted;
    logic             ge;
    logic [32:0]      diff;
    logic [31:0]      n_rem;

    assign req_acc = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    assign shifted = {r_rem, r_dividend[31]};
    assign ge      = shifted >= {1'b0, r_bucket};
    assign diff    = shifted - {1'b0, r_bucket};
    assign n_rem   = ge ? diff[31:0] : shifted[31:0];

    always_comb begin
        n_state     = r_state;
        o_stall     = 1'b1;
        o_cfg_ready = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall     = 1'b0;
                o_cfg_ready = 1'b1;
                if (i_valid && i_req.end_of_key) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= FNV_OFFSET_BASIS;
            r_bucket    <= BUCKET_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket <= i_cfg_data;
            end
            if (req_acc) begin
                r_hash <= i_req.end_of_key ? FNV_OFFSET_BASIS : fnv_step(r_hash, i_req.key_byte);
            end
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc && i_req.end_of_key) begin
            r_res_hash <= r_hash;
            r_dividend <= r_hash;
            r_rem      <= '0;
        end else if (r_state == ST_DIV) begin
            r_dividend <= {r_dividend[30:0], 1'b0};
            r_rem      <= n_rem;
        end
        if (out_load) begin
            r_rsp.hash_value   <= r_res_hash;
            r_rsp.bucket_index <= (r_bucket == '0) ? '0 : r_rem;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    a_term_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.end_of_key) |=> (r_state == ST_DIV && r_hash == FNV_OFFSET_BASIS))
        else $error("terminator did not start the divider and restart the hash");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_bucket != '0) |=> (r_rem < r_bucket))
        else $error("divider remainder reached the bucket count");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && o_rsp.hash_value == $past(r_res_hash)))
        else $error("finished hash not presented at the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> !i_stall)
        else $error("pending result overwritten");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (o_stall && !o_cfg_ready))
        else $error("request or config accepted during division");

endmodule
